/* sv/voxel_face_mesher_defines.svh */
// assertion macros of the voxel face mesher, used by vfm_ctrl
`ifndef VOXEL_FACE_MESHER_DEFINES_SVH
`define VOXEL_FACE_MESHER_DEFINES_SVH

// plain property checked every clock outside reset
`define VFM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// same-cycle implication
`define VFM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VFM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/vfm_pkg.sv */
// types, constants and helpers of the voxel face mesher
`default_nettype none

package vfm_pkg;

    localparam int CHUNK_WIDTH  = 16;
    localparam int CHUNK_HEIGHT = 128;

    localparam int POS_XZ_W  = 4;
    localparam int POS_Y_W   = 7;
    localparam int CODE_W    = 8;
    localparam int REQ_W     = 2;
    localparam int ORG_W     = 21;
    localparam int WORLD_W   = 22;
    localparam int WY_W      = 8;
    localparam int VCNT_W    = 20;
    localparam int FACE_W    = 3;
    localparam int NUM_FACES = 6;
    localparam int CFG_IDX_W = 2;

    localparam int STORE_DEPTH = CHUNK_WIDTH * CHUNK_HEIGHT * CHUNK_WIDTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // scan reads the center and then each neighbor, data arrives in the cycle after its address
    localparam int SCAN_LAST = NUM_FACES + 1;
    localparam int CNT_W     = $clog2(SCAN_LAST + 1);

    localparam logic [VCNT_W-1:0] VCNT_STEP = VCNT_W'(4);

    localparam int IN_BITS     = POS_XZ_W + POS_Y_W + POS_XZ_W + CODE_W;
    localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
    localparam int IN_USER_W   = REQ_W;
    localparam int OUT_BITS    = CODE_W + WORLD_W + WY_W + WORLD_W + VCNT_W;
    localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_USER_W  = FACE_W;

    // corner offsets per face, bit k belongs to face k
    localparam logic [NUM_FACES-1:0] FACE_CORNER_X = 6'b010110;
    localparam logic [NUM_FACES-1:0] FACE_CORNER_Y = 6'b001000;
    localparam logic [NUM_FACES-1:0] FACE_CORNER_Z = 6'b100010;

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE = 2'd0,
        REQ_MESH  = 2'd1,
        REQ_BEGIN = 2'd2
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X = 2'd0,
        CFG_ORIGIN_Z = 2'd1,
        CFG_AIR      = 2'd2
    } cfg_idx_t;

    typedef enum logic [FACE_W-1:0] {
        FACE_NX = 3'd0,
        FACE_PX = 3'd1,
        FACE_NY = 3'd2,
        FACE_PY = 3'd3,
        FACE_NZ = 3'd4,
        FACE_PZ = 3'd5
    } face_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic signed [ORG_W-1:0] origin_x;
        logic signed [ORG_W-1:0] origin_z;
        logic [CODE_W-1:0]       air;
    } cfg_t;

    typedef struct packed {
        logic                mesh;
        logic                clear;
        logic [POS_XZ_W-1:0] x;
        logic [POS_Y_W-1:0]  y;
        logic [POS_XZ_W-1:0] z;
    } cmd_t;

    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [POS_XZ_W-1:0] x,
        input logic [POS_Y_W-1:0]  y,
        input logic [POS_XZ_W-1:0] z
    );
        return ADDR_W'(x) * ADDR_W'(CHUNK_HEIGHT * CHUNK_WIDTH)
             + ADDR_W'(y) * ADDR_W'(CHUNK_WIDTH)
             + ADDR_W'(z);
    endfunction

endpackage

`default_nettype wire

/* sv/vfm_ram.sv */
// single-port-write, single-port-read block memory with registered read data
`default_nettype none

module vfm_ram #(
    parameter int ADDR_W = 15,
    parameter int DATA_W = 8
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* sv/vfm_ctrl.sv */
// mesh sequencer: reads voxel and neighbors, builds face mask, emits face results
`default_nettype none
`include "voxel_face_mesher_defines.svh"

module vfm_ctrl
    import vfm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire cfg_t                  cfg,
    input  wire cmd_t                  cmd,
    output logic                       idle,
    output logic [ADDR_W-1:0]          ram_raddr,
    input  wire logic [CODE_W-1:0]     ram_rdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic [OUT_USER_W-1:0]      m_tuser,
    output logic                       m_tlast
);

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [NUM_FACES-1:0]  mask_reg, mask_next;
    logic [VCNT_W-1:0]     vcount_reg, vcount_next;
    logic                  m_tvalid_reg, m_tvalid_next;

    logic [POS_XZ_W-1:0]   x_reg, z_reg;
    logic [POS_Y_W-1:0]    y_reg;
    logic [CODE_W-1:0]     center_reg;

    face_t                 face_reg;
    logic [CODE_W-1:0]     block_reg;
    logic [WORLD_W-1:0]    wx_reg, wz_reg;
    logic [WY_W-1:0]       wy_reg;
    logic [VCNT_W-1:0]     base_reg;
    logic                  m_tlast_reg;

    logic [ADDR_W-1:0]     center_addr;
    logic [ADDR_W-1:0]     nbr_addr [NUM_FACES];
    logic [NUM_FACES-1:0]  nbr_out;
    face_t                 sel;
    logic [NUM_FACES-1:0]  mask_clr;
    logic                  out_free;
    logic                  out_load;
    logic [WORLD_W-1:0]    wx, wz;
    logic [WY_W-1:0]       wy;

    function automatic face_t first_face(input logic [NUM_FACES-1:0] m);
        face_t f;
        f = FACE_NX;
        for (int i = NUM_FACES - 1; i >= 0; i--) begin
            if (m[i]) begin
                f = face_t'(FACE_W'(i));
            end
        end
        return f;
    endfunction

    // neighbor addresses and chunk-edge flags around the latched voxel
    always_comb begin
        center_addr        = cell_addr(x_reg, y_reg, z_reg);
        nbr_addr[FACE_NX]  = cell_addr(POS_XZ_W'(x_reg - 1'b1), y_reg, z_reg);
        nbr_addr[FACE_PX]  = cell_addr(POS_XZ_W'(x_reg + 1'b1), y_reg, z_reg);
        nbr_addr[FACE_NY]  = cell_addr(x_reg, POS_Y_W'(y_reg - 1'b1), z_reg);
        nbr_addr[FACE_PY]  = cell_addr(x_reg, POS_Y_W'(y_reg + 1'b1), z_reg);
        nbr_addr[FACE_NZ]  = cell_addr(x_reg, y_reg, POS_XZ_W'(z_reg - 1'b1));
        nbr_addr[FACE_PZ]  = cell_addr(x_reg, y_reg, POS_XZ_W'(z_reg + 1'b1));
        nbr_out[FACE_NX]   = (x_reg == '0);
        nbr_out[FACE_PX]   = (x_reg == POS_XZ_W'(CHUNK_WIDTH - 1));
        nbr_out[FACE_NY]   = (y_reg == '0);
        nbr_out[FACE_PY]   = (y_reg == POS_Y_W'(CHUNK_HEIGHT - 1));
        nbr_out[FACE_NZ]   = (z_reg == '0);
        nbr_out[FACE_PZ]   = (z_reg == POS_XZ_W'(CHUNK_WIDTH - 1));
    end

    always_comb begin
        sel      = first_face(mask_reg);
        mask_clr = mask_reg & ~(NUM_FACES'(1) << sel);
        wx = {cfg.origin_x[ORG_W-1], cfg.origin_x} + WORLD_W'(x_reg)
           + WORLD_W'(FACE_CORNER_X[sel]);
        wy = WY_W'(y_reg) + WY_W'(FACE_CORNER_Y[sel]);
        wz = {cfg.origin_z[ORG_W-1], cfg.origin_z} + WORLD_W'(z_reg)
           + WORLD_W'(FACE_CORNER_Z[sel]);
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        mask_next     = mask_reg;
        vcount_next   = vcount_reg;
        m_tvalid_next = m_tvalid_reg;
        ram_raddr     = center_addr;
        out_free      = !m_tvalid_reg || m_tready;
        out_load      = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (cmd.clear) begin
            vcount_next = '0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (cmd.mesh) begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                    mask_next  = '0;
                end
            end
            ST_SCAN: begin
                for (int k = 0; k < NUM_FACES; k++) begin
                    if (cnt_reg == CNT_W'(k + 1)) begin
                        ram_raddr = nbr_addr[k];
                    end
                    // read data of neighbor k arrives in the cycle after its address
                    if (cnt_reg == CNT_W'(k + 2)) begin
                        mask_next[k] = nbr_out[k] || (ram_rdata == cfg.air);
                    end
                end
                if (cnt_reg == CNT_W'(SCAN_LAST)) begin
                    cnt_next = '0;
                    if ((center_reg == cfg.air) || (mask_next == '0)) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    m_tvalid_next = 1'b1;
                    mask_next     = mask_clr;
                    vcount_next   = vcount_reg + VCNT_STEP;
                    if (mask_clr == '0) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            mask_reg     <= '0;
            vcount_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            mask_reg     <= mask_next;
            vcount_reg   <= vcount_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && cmd.mesh) begin
            x_reg <= cmd.x;
            y_reg <= cmd.y;
            z_reg <= cmd.z;
        end
        if (state_reg == ST_SCAN && cnt_reg == CNT_W'(1)) begin
            center_reg <= ram_rdata;
        end
        if (out_load) begin
            face_reg    <= sel;
            block_reg   <= center_reg;
            wx_reg      <= wx;
            wy_reg      <= wy;
            wz_reg      <= wz;
            base_reg    <= vcount_reg;
            m_tlast_reg <= (mask_clr == '0);
        end
    end

    assign idle     = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_DATA_W'({base_reg, wz_reg, wy_reg, wx_reg, block_reg});
    assign m_tuser  = face_reg;
    assign m_tlast  = m_tlast_reg;

    `VFM_ASSERT_NEXT(a_vcount_step, out_load, (vcount_reg - $past(vcount_reg)) == VCNT_STEP, "vertex counter did not advance by four on a face result")
    `VFM_ASSERT_IMPL(a_emit_mask, state_reg == ST_EMIT, mask_reg != '0, "emit state with empty face mask")
    `VFM_ASSERT_IMPL(a_cnt_rest, state_reg != ST_SCAN, cnt_reg == '0, "scan counter left nonzero outside scan")
    `VFM_ASSERT_NEXT(a_last_idle, out_load && (mask_clr == '0), (state_reg == ST_IDLE) && m_tvalid_reg && m_tlast_reg, "final face did not end the voxel")

endmodule

`default_nettype wire

/* sv/voxel_face_mesher.sv */
// voxel_face_mesher top level: stream ports, config registers and block store
//
// input transactions on s_* carry a request kind in s_tuser: write block stores
// block_code at (pos_x, pos_y, pos_z), begin clears the vertex counter, mesh
// checks one voxel and emits one m_* transaction per exposed face in the order
// -x, +x, -y, +y, -z, +z, with m_tlast on the last face of that voxel.
// config writes (cfg_index 0 origin x, 1 origin z, 2 air code) are taken every
// cycle and are meant to arrive while the block is idle.
// a mesh transaction reads the center voxel and its six neighbors through the
// single read port of the block memory, then emits one exposed face per cycle
// while the output register is free.
// s_tready is high whenever no mesh is in progress; a result waiting in the
// output register does not hold off the next input transaction.
// when the receiver stalls, face emission pauses and the output holds.
// reset clears the vertex counter, control state and config registers; the
// block memory is not cleared and must be written before it is meshed.
`default_nettype none

module voxel_face_mesher
    import vfm_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [IN_DATA_W-1:0]     s_tdata,   // pos_x, pos_y, pos_z, block_code
    input  wire logic [IN_USER_W-1:0]     s_tuser,   // req_type
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [OUT_DATA_W-1:0]         m_tdata,   // face_block, origin_x, origin_y,
                                                     // origin_z, base_vertex
    output logic [OUT_USER_W-1:0]         m_tuser,   // face_code
    output logic                          m_tlast,   // last_face
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ORG_W-1:0]         cfg_data
);

    cfg_t                 cfg_reg;
    cmd_t                 cmd;
    logic                 ctrl_idle;
    logic                 in_acc;
    logic                 in_bounds;
    req_t                 req;
    logic [POS_XZ_W-1:0]  pos_x, pos_z;
    logic [POS_Y_W-1:0]   pos_y;
    logic [CODE_W-1:0]    block_code;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [CODE_W-1:0]    ram_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_ORIGIN_X: cfg_reg.origin_x <= cfg_data;
                CFG_ORIGIN_Z: cfg_reg.origin_z <= cfg_data;
                CFG_AIR:      cfg_reg.air      <= cfg_data[CODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign pos_x      = s_tdata[POS_XZ_W-1:0];
    assign pos_y      = s_tdata[POS_XZ_W+POS_Y_W-1:POS_XZ_W];
    assign pos_z      = s_tdata[2*POS_XZ_W+POS_Y_W-1:POS_XZ_W+POS_Y_W];
    assign block_code = s_tdata[IN_BITS-1:2*POS_XZ_W+POS_Y_W];
    assign req        = req_t'(s_tuser);

    assign s_tready  = ctrl_idle;
    assign in_acc    = s_tvalid && s_tready;
    assign in_bounds = (int'(pos_x) < CHUNK_WIDTH) && (int'(pos_y) < CHUNK_HEIGHT)
                    && (int'(pos_z) < CHUNK_WIDTH);

    always_comb begin
        ram_we    = 1'b0;
        cmd.mesh  = 1'b0;
        cmd.clear = 1'b0;
        cmd.x     = pos_x;
        cmd.y     = pos_y;
        cmd.z     = pos_z;
        case (req)
            REQ_WRITE: ram_we    = in_acc && in_bounds;
            REQ_MESH:  cmd.mesh  = in_acc && in_bounds;
            REQ_BEGIN: cmd.clear = in_acc;
            default: begin
            end
        endcase
    end

    vfm_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (CODE_W)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cell_addr(pos_x, pos_y, pos_z)),
        .wdata (block_code),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    vfm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .idle      (ctrl_idle),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

/* test/voxel_face_mesher_tb.sv */
// self-checking testbench for the voxel face mesher: random and directed streams against a predictor
`default_nettype none

module voxel_face_mesher_tb
    import vfm_pkg::*;
();

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 20;
    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic [REQ_W-1:0]    req;
        logic [POS_XZ_W-1:0] x;
        logic [POS_Y_W-1:0]  y;
        logic [POS_XZ_W-1:0] z;
        logic [CODE_W-1:0]   code;
    } voxel_req_t;

    typedef struct packed {
        face_t               face;
        logic [CODE_W-1:0]   blk;
        logic [WORLD_W-1:0]  ox;
        logic [WY_W-1:0]     oy;
        logic [WORLD_W-1:0]  oz;
        logic [VCNT_W-1:0]   base;
        logic                last;
    } face_quad_t;

    // predicts the face quads of each mesh transaction and checks them in order
    class face_scoreboard;
        logic [CODE_W-1:0] chunk [STORE_DEPTH];
        logic [ORG_W-1:0]  org_x;
        logic [ORG_W-1:0]  org_z;
        logic [CODE_W-1:0] air;
        logic [VCNT_W-1:0] vcount;
        face_quad_t        quads [$];
        int                errors;

        function new();
            org_x  = '0;
            org_z  = '0;
            air    = '0;
            vcount = '0;
            errors = 0;
        endfunction

        function int slot(int x, int y, int z);
            return (x * CHUNK_HEIGHT + y) * CHUNK_WIDTH + z;
        endfunction

        function bit in_chunk(int x, int y, int z);
            return x >= 0 && x < CHUNK_WIDTH && y >= 0 && y < CHUNK_HEIGHT &&
                   z >= 0 && z < CHUNK_WIDTH;
        endfunction

        // neighbor step and quad corner offset of each face
        function void face_offsets(face_t f, output int dx, output int dy, output int dz,
                                   output int cx, output int cy, output int cz);
            dx = 0; dy = 0; dz = 0;
            cx = 0; cy = 0; cz = 0;
            case (f)
                FACE_NX: begin
                    dx = -1;
                end
                FACE_PX: begin
                    dx = 1; cx = 1; cz = 1;
                end
                FACE_NY: begin
                    dy = -1; cx = 1;
                end
                FACE_PY: begin
                    dy = 1; cy = 1;
                end
                FACE_NZ: begin
                    dz = -1; cx = 1;
                end
                default: begin
                    dz = 1; cz = 1;
                end
            endcase
        endfunction

        function void set_reg(cfg_idx_t idx, logic [ORG_W-1:0] val);
            case (idx)
                CFG_ORIGIN_X: org_x = val;
                CFG_ORIGIN_Z: org_z = val;
                CFG_AIR:      air   = val[CODE_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_input(voxel_req_t r);
            int x, y, z, dx, dy, dz, cx, cy, cz, wx, wz, first;
            logic [CODE_W-1:0] owner;
            face_t f;
            face_quad_t q;
            x = r.x;
            y = r.y;
            z = r.z;
            if (r.req == REQ_BEGIN) begin
                vcount = '0;
            end else if (r.req == REQ_WRITE) begin
                chunk[slot(x, y, z)] = r.code;
            end else if (r.req == REQ_MESH) begin
                owner = chunk[slot(x, y, z)];
                if (owner != air) begin
                    first = quads.size();
                    for (int k = 0; k < NUM_FACES; k++) begin
                        f = face_t'(k);
                        face_offsets(f, dx, dy, dz, cx, cy, cz);
                        if (!in_chunk(x + dx, y + dy, z + dz) ||
                            chunk[slot(x + dx, y + dy, z + dz)] == air) begin
                            wx = $signed(org_x) + x + cx;
                            wz = $signed(org_z) + z + cz;
                            q.face = f;
                            q.blk  = owner;
                            q.ox   = wx[WORLD_W-1:0];
                            q.oy   = WY_W'(y + cy);
                            q.oz   = wz[WORLD_W-1:0];
                            q.base = vcount;
                            q.last = 1'b0;
                            quads = {quads, q};
                            vcount = vcount + VCNT_W'(4);
                        end
                    end
                    if (quads.size() > first)
                        quads[quads.size() - 1].last = 1'b1;
                end
            end
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10)
                $display("%s", msg);
        endfunction

        function void check_result(face_quad_t got);
            face_quad_t want;
            if (quads.size() == 0) begin
                report($sformatf("unexpected face %0d block %0d base %0d", got.face, got.blk,
                                 got.base));
                return;
            end
            want = quads.pop_front();
            if (got.face !== want.face || got.blk !== want.blk || got.ox !== want.ox ||
                got.oy !== want.oy || got.oz !== want.oz || got.base !== want.base ||
                got.last !== want.last)
                report($sformatf({"face mismatch: expected face %0d blk %0d org (%0d,%0d,%0d) ",
                                  "base %0d last %0d, got face %0d blk %0d org (%0d,%0d,%0d) ",
                                  "base %0d last %0d"},
                                 want.face, want.blk, $signed(want.ox), want.oy,
                                 $signed(want.oz), want.base, want.last,
                                 got.face, got.blk, $signed(got.ox), got.oy,
                                 $signed(got.oz), got.base, got.last));
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;   // pos_x, pos_y, pos_z, block_code
    logic [IN_USER_W-1:0]  s_tuser   = '0;   // req_type
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;          // face_block, origin_x, origin_y, origin_z,
                                             // base_vertex
    logic [OUT_USER_W-1:0] m_tuser;          // face_code
    logic                  m_tlast;          // last_face
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index = CFG_ORIGIN_X;
    logic [ORG_W-1:0]      cfg_data  = '0;

    face_scoreboard sb;
    voxel_req_t     plan [$];
    bit             planned [STORE_DEPTH];
    bit             tx_idle_on = 1'b1;
    bit             rx_idle_on = 1'b1;
    bit             hold_req   = 1'b0;
    int             quiet_cycles = 0;
    int             win_x, win_y, win_z;
    voxel_req_t     in_seen;
    face_quad_t     out_seen;

    voxel_face_mesher i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------- monitors ----------------

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            in_seen.req  = s_tuser;
            in_seen.x    = s_tdata[3:0];
            in_seen.y    = s_tdata[10:4];
            in_seen.z    = s_tdata[14:11];
            in_seen.code = s_tdata[22:15];
            sb.note_input(in_seen);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            out_seen.face = face_t'(m_tuser);
            out_seen.blk  = m_tdata[7:0];
            out_seen.ox   = m_tdata[29:8];
            out_seen.oy   = m_tdata[37:30];
            out_seen.oz   = m_tdata[59:38];
            out_seen.base = m_tdata[79:60];
            out_seen.last = m_tlast;
            sb.check_result(out_seen);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------- receiver ----------------

    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                // long stall so the block fills up and blocks its input
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                m_tready <= 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------- drivers ----------------

    task automatic write_reg(input cfg_idx_t idx, input logic [ORG_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [ORG_W-1:0] ox, input logic [ORG_W-1:0] oz,
                              input logic [CODE_W-1:0] air);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Z, oz);
        write_reg(CFG_AIR, ORG_W'(air));
    endtask

    task automatic send_item(input voxel_req_t it);
        @(negedge aclk);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'({it.code, it.z, it.y, it.x});
        s_tuser  <= it.req;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_plan();
        while (plan.size() != 0)
            send_item(plan.pop_front());
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // wait for every predicted face, then let a mesh with no faces finish
    task automatic drain();
        while (sb.quads.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // ---------------- stimulus planning ----------------

    function automatic logic [CODE_W-1:0] pick_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return sb.air;
        if (r < 55)
            return sb.air + CODE_W'(1);
        return CODE_W'($urandom_range(0, 255));
    endfunction

    function automatic void plan_item(input logic [REQ_W-1:0] req, input int x, input int y,
                                      input int z, input logic [CODE_W-1:0] code);
        voxel_req_t it;
        it.req  = req;
        it.x    = POS_XZ_W'(x);
        it.y    = POS_Y_W'(y);
        it.z    = POS_XZ_W'(z);
        it.code = code;
        plan = {plan, it};
        if (req == REQ_WRITE)
            planned[sb.slot(x, y, z)] = 1'b1;
    endfunction

    // writes whatever the mesh would read that is still unwritten, then meshes
    function automatic int plan_mesh_ready(input int x, input int y, input int z);
        int dx, dy, dz, cx, cy, cz, added;
        added = 0;
        if (!planned[sb.slot(x, y, z)]) begin
            plan_item(REQ_WRITE, x, y, z, pick_code());
            added++;
        end
        for (int k = 0; k < NUM_FACES; k++) begin
            sb.face_offsets(face_t'(k), dx, dy, dz, cx, cy, cz);
            if (sb.in_chunk(x + dx, y + dy, z + dz) &&
                !planned[sb.slot(x + dx, y + dy, z + dz)]) begin
                plan_item(REQ_WRITE, x + dx, y + dy, z + dz, pick_code());
                added++;
            end
        end
        plan_item(REQ_MESH, x, y, z, CODE_W'($urandom_range(0, 255)));
        return added + 1;
    endfunction

    function automatic int pick_coord(input int lo, input int top);
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(0, 1) ? top : 0;
        return lo + $urandom_range(0, 2);
    endfunction

    function automatic void plan_directed();
        // lone voxel at the low corner: all six faces
        plan_item(REQ_WRITE, 0, 0, 0, 8'hFF);
        plan_item(REQ_WRITE, 1, 0, 0, 8'h00);
        plan_item(REQ_WRITE, 0, 1, 0, 8'h00);
        plan_item(REQ_WRITE, 0, 0, 1, 8'h00);
        plan_item(REQ_MESH, 0, 0, 0, 8'h00);
        // high corner with solid neighbors: only the faces at the chunk edge
        plan_item(REQ_WRITE, 15, 127, 15, 8'h80);
        plan_item(REQ_WRITE, 14, 127, 15, 8'h01);
        plan_item(REQ_WRITE, 15, 126, 15, 8'h7F);
        plan_item(REQ_WRITE, 15, 127, 14, 8'hFE);
        plan_item(REQ_MESH, 15, 127, 15, 8'hFF);
        // air voxel gives nothing
        void'(plan_mesh_ready(1, 0, 0));
        plan_item(REQ_UNUSED, 15, 127, 15, 8'hFF);
        plan_item(REQ_MESH, 0, 0, 0, 8'h55);
        plan_item(REQ_BEGIN, 0, 0, 0, 8'h00);
        plan_item(REQ_MESH, 15, 127, 15, 8'hAA);
    endfunction

    function automatic void plan_random(input int count);
        int made, pick, x, y, z;
        win_x = $urandom_range(0, CHUNK_WIDTH - 3);
        win_y = $urandom_range(0, CHUNK_HEIGHT - 3);
        win_z = $urandom_range(0, CHUNK_WIDTH - 3);
        made  = 0;
        while (made < count) begin
            pick = $urandom_range(0, 99);
            x = pick_coord(win_x, CHUNK_WIDTH - 1);
            y = pick_coord(win_y, CHUNK_HEIGHT - 1);
            z = pick_coord(win_z, CHUNK_WIDTH - 1);
            if (pick < 60) begin
                made += plan_mesh_ready(x, y, z);
            end else if (pick < 75) begin
                plan_item(REQ_WRITE, x, y, z, pick_code());
                made++;
            end else if (pick < 82) begin
                plan_item(REQ_BEGIN, $urandom_range(0, 15), $urandom_range(0, 127),
                          $urandom_range(0, 15), CODE_W'($urandom_range(0, 255)));
                made++;
            end else if (pick < 88) begin
                plan_item(REQ_UNUSED, $urandom_range(0, 15), $urandom_range(0, 127),
                          $urandom_range(0, 15), CODE_W'($urandom_range(0, 255)));
            end else begin
                // scattered write anywhere in the chunk
                plan_item(REQ_WRITE, $urandom_range(0, 15), $urandom_range(0, 127),
                          $urandom_range(0, 15), CODE_W'($urandom_range(0, 255)));
                made++;
            end
        end
    endfunction

    // ---------------- main sequence ----------------

    initial begin
        sb = new();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_config(21'h0FFFFF, 21'h100000, 8'h00);
        plan_directed();
        send_plan();
        drain();

        set_config(21'h100000, 21'h0FFFFF, 8'hFF);
        plan_random(100);
        @(posedge aclk);
        hold_req = 1'b1;
        send_plan();
        drain();

        set_config(ORG_W'($urandom), ORG_W'($urandom), CODE_W'($urandom_range(0, 255)));
        plan_random(50);
        send_plan();
        drain();
        plan_random(50);
        send_plan();
        drain();

        // closing stretch at full rate on both sides
        @(posedge aclk);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        set_config('0, '0, CODE_W'($urandom_range(0, 255)));
        plan_random(120);
        send_plan();
        drain();

        if (sb.errors == 0 && sb.quads.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
